>>> src/sprng_pkg.sv
// ----------------------------------------------------------------------------
// sprng_pkg: shared constants of the selectable 64-bit generator
// Algorithm codes, mixing constants, warm-up step counts and a rotate helper.
// ----------------------------------------------------------------------------
package sprng_pkg;

  localparam logic [2:0] ALG_SPLITMIX = 3'd0;
  localparam logic [2:0] ALG_JSF      = 3'd1;
  localparam logic [2:0] ALG_SFC      = 3'd2;
  localparam logic [2:0] ALG_XOSHIRO  = 3'd3;
  localparam logic [2:0] ALG_XSM      = 3'd4;

  localparam logic [63:0] GOLDEN_INC    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A         = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B         = 64'h94D049BB133111EB;
  localparam logic [63:0] XSM_MUL       = 64'hA3EC647659359ACD;
  localparam logic [63:0] JSF_SEED_WORD = 64'h00000000F1EA5EED;
  localparam logic [4:0]  JSF_WARMUP    = 5'd20;
  localparam logic [4:0]  SFC_WARMUP    = 5'd12;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (64 - n));
  endfunction

endpackage

>>> src/sprng_mul.sv
// ----------------------------------------------------------------------------
// sprng_mul: shared 64x64 low-half multiplier
// Forms the low 64 bits of a product from three 32x32 partial products, one
// per cycle (the high-by-high product never reaches the low half); done
// pulses for one cycle with the registered product.
// ----------------------------------------------------------------------------
module sprng_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] ra, rb;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  always_comb begin
    case (step)
      2'd0: begin op_a = ra[31:0];  op_b = rb[31:0];  end
      2'd1: begin op_a = ra[63:32]; op_b = rb[31:0];  end
      2'd2: begin op_a = ra[31:0];  op_b = rb[63:32]; end
      default: begin op_a = 32'd0;  op_b = 32'd0;     end
    endcase
  end

  assign pp = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ra   <= a;
        rb   <= b;
        busy <= 1'b1;
        step <= 2'd0;
        p    <= 64'd0;
      end else if (busy) begin
        if (step == 2'd0) p <= pp;
        else p <= p + {pp[31:0], 32'd0};
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

endmodule

>>> src/selectable_prng_64.sv
// ----------------------------------------------------------------------------
// selectable_prng_64: 64-bit generator with five selectable algorithms
// ----------------------------------------------------------------------------
// Usage: the algorithm register (address 0, values 0..4; 5..7 act as 0)
// is written over the APB-style port while the block is idle.
// Input transactions carry req_type and seed_value. req_type 0 reseeds the
// shared 256-bit state and produces no output; req_type 1 advances the state
// and produces one random_value transaction.
// Every 64-bit multiply goes through one shared multiplier. For jsf64,
// sfc64 and xoshiro256** a next transaction is computed in the idle state
// and registered into the output register at acceptance; splitmix64 and
// xsm64 need two dependent multiplies. Seeding splitmix64 only loads the
// state; the other seedings run splitmix64 expansion words, followed by
// warm-up steps for jsf64 and sfc64 and by finishing states for xsm64.
// in_ready is low while a transaction is in work or a result is held in the
// output register; a stalled receiver simply holds the block.
// Reset clears the state words to zero and the algorithm to splitmix64.
// ----------------------------------------------------------------------------
module selectable_prng_64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] random_value
);

  localparam logic [1:0] ADDR_ALGORITHM = 2'd0;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SMA  = 4'd1;  // expansion or splitmix64 step, first multiply
  localparam logic [3:0] ST_SMB  = 4'd2;
  localparam logic [3:0] ST_SMC  = 4'd3;
  localparam logic [3:0] ST_WARM = 4'd4;
  localparam logic [3:0] ST_XFWD = 4'd5;  // xsm64 seeding finish
  localparam logic [3:0] ST_XADD = 4'd6;
  localparam logic [3:0] ST_XA   = 4'd7;  // xsm64 next
  localparam logic [3:0] ST_XB   = 4'd8;
  localparam logic [3:0] ST_XC   = 4'd9;

  logic [3:0]  state;
  logic [2:0]  algorithm;
  logic [2:0]  alg;
  logic [63:0] s0, s1, s2, s3;
  logic [63:0] t, e0, e1, e2;  // held last expansion word and stored expansion results
  logic [1:0]  cnt;            // expansion word index
  logic [1:0]  last;
  logic [4:0]  warm;
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        wr;

  sprng_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_ALGORITHM) ? {29'd0, algorithm} : 32'd0;
  assign wr       = psel && penable && pwrite && (paddr == ADDR_ALGORITHM);
  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    alg = algorithm;
    if (algorithm > sprng_pkg::ALG_XSM) alg = sprng_pkg::ALG_SPLITMIX;
  end

  // xoshiro256** uses four expansion words; jsf64, sfc64 and xsm64 use three.
  assign last = (alg == sprng_pkg::ALG_XOSHIRO) ? 2'd3 : 2'd2;

  // Combinational step functions of the multiply-free algorithms, plus the multiply-free parts of xsm64.
  logic [63:0] je, j0, j1, j2, j3;
  logic [63:0] ft, f0, f1, f2, f3;
  logic [63:0] xa, xb, xc, xd, xy, xr;
  logic [63:0] fwd2, fwd3;
  logic [63:0] xt0, xt1;
  always_comb begin
    je = s0 - sprng_pkg::rotl(s1, 7);
    j0 = s1 ^ sprng_pkg::rotl(s2, 13);
    j1 = s2 + sprng_pkg::rotl(s3, 37);
    j2 = s3 + je;
    j3 = j0 + je;
    ft = s0 + s1 + s3;
    f3 = s3 + 64'd1;
    f0 = s1 ^ (s1 >> 11);
    f1 = s2 + (s2 << 3);
    f2 = sprng_pkg::rotl(s2, 24) + ft;
    xc = s2 ^ s0;
    xd = s3 ^ s1;
    xb = s1 ^ xc;
    xa = s0 ^ xd;
    // Multiplying by 5 and by 9 reduces to a shift and an add.
    xy = sprng_pkg::rotl(s1 + (s1 << 2), 7);
    xr = xy + (xy << 3);
    fwd2 = s2 + s0;
    fwd3 = s3 + (s2 + s1) + {63'd0, (fwd2 < s0)};
    xt0 = s3 ^ sprng_pkg::rotl(s3 + s2, 16);
    xt1 = xt0 ^ sprng_pkg::rotl(xt0 + s1, 40);
  end

  logic [63:0] smz;
  assign smz = s3 ^ (s3 >> 30);

  always_comb begin
    mul_start = 1'b0;
    mul_a = smz;
    mul_b = sprng_pkg::MIX_A;
    case (state)
      ST_SMA: mul_start = 1'b1;
      ST_SMB: begin
        mul_start = mul_done;
        mul_a = mul_p ^ (mul_p >> 27);
        mul_b = sprng_pkg::MIX_B;
      end
      ST_XA: begin
        mul_start = 1'b1;
        mul_a = xt1;
        mul_b = sprng_pkg::XSM_MUL;
      end
      ST_XB: begin
        mul_start = mul_done;
        mul_a = mul_p ^ sprng_pkg::rotl(mul_p + s3, 32);
        mul_b = sprng_pkg::XSM_MUL;
      end
      default: ;
    endcase
  end

  logic [63:0] smr;
  assign smr = mul_p ^ (mul_p >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      algorithm <= sprng_pkg::ALG_SPLITMIX;
      out_valid <= 1'b0;
      s0 <= 64'd0; s1 <= 64'd0; s2 <= 64'd0; s3 <= 64'd0;
      cnt <= 2'd0;
      warm <= 5'd0;
    end else begin
      if (wr) algorithm <= pwdata[2:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (!req_type) begin
              s0 <= {32'd0, seed_value}; s1 <= {32'd0, seed_value};
              s2 <= {32'd0, seed_value}; s3 <= {32'd0, seed_value};
              cnt <= 2'd0;
              if (alg != sprng_pkg::ALG_SPLITMIX) state <= ST_SMA;
            end else begin
              case (alg)
                sprng_pkg::ALG_JSF: begin
                  s0 <= j0; s1 <= j1; s2 <= j2; s3 <= j3;
                  random_value <= j3; out_valid <= 1'b1;
                end
                sprng_pkg::ALG_SFC: begin
                  s0 <= f0; s1 <= f1; s2 <= f2; s3 <= f3;
                  random_value <= ft; out_valid <= 1'b1;
                end
                sprng_pkg::ALG_XOSHIRO: begin
                  s0 <= xa; s1 <= xb; s2 <= xc ^ (s1 << 17);
                  s3 <= sprng_pkg::rotl(xd, 45);
                  random_value <= xr; out_valid <= 1'b1;
                end
                sprng_pkg::ALG_XSM: state <= ST_XA;
                default: state <= ST_SMA;
              endcase
            end
          end
        end
        ST_SMA: begin
          s3 <= s3 + sprng_pkg::GOLDEN_INC;
          state <= ST_SMB;
        end
        ST_SMB: if (mul_done) state <= ST_SMC;
        ST_SMC: begin
          if (mul_done) begin
            if (alg == sprng_pkg::ALG_SPLITMIX) begin
              random_value <= smr; out_valid <= 1'b1; state <= ST_IDLE;
            end else begin
              case (cnt)
                2'd0: e0 <= smr;
                2'd1: e1 <= smr;
                2'd2: e2 <= smr;
                default: ;
              endcase
              if (cnt == last) begin
                case (alg)
                  sprng_pkg::ALG_JSF: begin
                    s0 <= sprng_pkg::JSF_SEED_WORD; s1 <= e0; s2 <= e1; s3 <= smr;
                    warm <= sprng_pkg::JSF_WARMUP;
                    state <= ST_WARM;
                  end
                  sprng_pkg::ALG_SFC: begin
                    s0 <= e0; s1 <= e1; s2 <= smr; s3 <= 64'd1;
                    warm <= sprng_pkg::SFC_WARMUP;
                    state <= ST_WARM;
                  end
                  sprng_pkg::ALG_XOSHIRO: begin
                    s0 <= e0; s1 <= e1; s2 <= e2; s3 <= smr;
                    state <= ST_IDLE;
                  end
                  default: begin
                    s0 <= {e0[62:0], 1'b1};
                    s1 <= {e1[62:0], e0[63]};
                    s2 <= {e0[62:0], 1'b1};
                    s3 <= {e1[62:0], e0[63]} ^ {e1[63], 63'd0};
                    t  <= smr;
                    state <= ST_XFWD;
                  end
                endcase
              end else begin
                cnt <= cnt + 2'd1;
                state <= ST_SMA;
              end
            end
          end
        end
        ST_WARM: begin
          if (warm == 5'd0) state <= ST_IDLE;
          else begin
            warm <= warm - 5'd1;
            if (alg == sprng_pkg::ALG_JSF) begin
              s0 <= j0; s1 <= j1; s2 <= j2; s3 <= j3;
            end else begin
              s0 <= f0; s1 <= f1; s2 <= f2; s3 <= f3;
            end
          end
        end
        ST_XFWD: begin
          s2 <= fwd2;
          s3 <= fwd3;
          state <= ST_XADD;
        end
        ST_XADD: begin
          s3 <= s3 + (t << 31);
          state <= ST_IDLE;
        end
        ST_XA: begin
          // The first multiply takes its operand from the state before the step.
          s2 <= fwd2; s3 <= fwd3; state <= ST_XB;
        end
        ST_XB: if (mul_done) state <= ST_XC;
        ST_XC: begin
          if (mul_done) begin
            random_value <= mul_p ^ (mul_p >> 32);
            out_valid <= 1'b1; state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> bench/tb_selectable_prng_64.sv
// ----------------------------------------------------------------------------
// tb_selectable_prng_64: self-checking bench for the selectable 64-bit PRNG
// Seed and next transactions are driven with random gaps under every
// algorithm setting, and each random_value is compared with a built-in
// predictor that keeps its own copy of the 256-bit state.
// ----------------------------------------------------------------------------
module tb_selectable_prng_64;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_NEXT = 1'b1;
  localparam logic [1:0] REG_ALGORITHM = 2'd0;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed;
  } req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [31:0] seed_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] random_value;

  req_t        pending_reqs[$];
  logic [63:0] expected_values[$];
  logic [63:0] st[4];
  logic [2:0]  alg_sel;
  int errors = 0;
  int cycles = 0;
  int values_seen = 0;
  int seeds_sent = 0;
  int hold_off = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  bit in_taken = 1'b0;

  selectable_prng_64 dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rl(logic [63:0] v, int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] golden_step();
    logic [63:0] z;
    z = st[3];
    st[3] = z + sprng_pkg::GOLDEN_INC;
    z = (z ^ (z >> 30)) * sprng_pkg::MIX_A;
    z = (z ^ (z >> 27)) * sprng_pkg::MIX_B;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] xoshiro_step();
    logic [63:0] r, t;
    r = rl(st[1] * 64'd5, 7) * 64'd9;
    t = st[1] << 17;
    st[2] ^= st[0];
    st[3] ^= st[1];
    st[1] ^= st[2];
    st[0] ^= st[3];
    st[2] ^= t;
    st[3] = rl(st[3], 45);
    return r;
  endfunction

  function automatic logic [63:0] jsf_step();
    logic [63:0] e;
    e = st[0] - rl(st[1], 7);
    st[0] = st[1] ^ rl(st[2], 13);
    st[1] = st[2] + rl(st[3], 37);
    st[2] = st[3] + e;
    st[3] = st[0] + e;
    return st[3];
  endfunction

  function automatic logic [63:0] sfc_step();
    logic [63:0] t;
    t = st[0] + st[1] + st[3];
    st[3] += 64'd1;
    st[0] = st[1] ^ (st[1] >> 11);
    st[1] = st[2] + (st[2] << 3);
    st[2] = rl(st[2], 24) + t;
    return t;
  endfunction

  function automatic void xsm_advance();
    logic [63:0] t;
    t = st[2] + st[1];
    st[2] += st[0];
    st[3] += t + ((st[2] < st[0]) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] xsm_step();
    logic [63:0] t;
    t = st[3] ^ rl(st[3] + st[2], 16);
    t ^= rl(t + st[1], 40);
    t *= sprng_pkg::XSM_MUL;
    xsm_advance();
    t ^= rl(t + st[3], 32);
    t *= sprng_pkg::XSM_MUL;
    t ^= t >> 32;
    return t;
  endfunction

  function automatic void reseed_state(logic [31:0] seed);
    logic [63:0] s1, s2, s3;
    for (int i = 0; i < 4; i++) st[i] = {32'd0, seed};
    case (alg_sel)
      sprng_pkg::ALG_JSF: begin
        st[0] = sprng_pkg::JSF_SEED_WORD;
        st[1] = golden_step();
        st[2] = golden_step();
        st[3] = golden_step();
        for (int i = 0; i < sprng_pkg::JSF_WARMUP; i++) void'(jsf_step());
      end
      sprng_pkg::ALG_SFC: begin
        st[0] = golden_step();
        st[1] = golden_step();
        st[2] = golden_step();
        st[3] = 64'd1;
        for (int i = 0; i < sprng_pkg::SFC_WARMUP; i++) void'(sfc_step());
      end
      sprng_pkg::ALG_XOSHIRO: begin
        st[0] = golden_step();
        st[1] = golden_step();
        st[2] = golden_step();
        st[3] = golden_step();
      end
      sprng_pkg::ALG_XSM: begin
        s1 = golden_step();
        s2 = golden_step();
        s3 = golden_step();
        st[0] = (s1 << 1) | 64'd1;
        st[1] = (s1 >> 63) | (s2 << 1);
        st[2] = st[0];
        st[3] = st[1] ^ ((s2 >> 63) << 63);
        xsm_advance();
        st[3] += s3 << 31;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] advance_state();
    case (alg_sel)
      sprng_pkg::ALG_JSF:     return jsf_step();
      sprng_pkg::ALG_SFC:     return sfc_step();
      sprng_pkg::ALG_XOSHIRO: return xoshiro_step();
      sprng_pkg::ALG_XSM:     return xsm_step();
      default:                return golden_step();
    endcase
  endfunction

  // Driver: the prediction is made when a transaction is accepted.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      in_taken = 1'b1;
      if (req_type == REQ_NEXT) expected_values.push_back(advance_state());
      else begin
        reseed_state(seed_value);
        seeds_sent <= seeds_sent + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_valid <= 1'b0;
        tx_gap = $urandom_range(0, 3);
      end else if (!in_valid) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.kind;
          seed_value <= r.seed;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      values_seen <= values_seen + 1;
      if (expected_values.size() == 0) begin
        $error("random_value: none expected, actual %h", random_value);
        errors++;
      end else begin
        logic [63:0] exp_v;
        exp_v = expected_values.pop_front();
        if (random_value !== exp_v) begin
          $error("random_value: expected %h, actual %h", exp_v, random_value);
          errors++;
        end
      end
    end
  end

  // Receiver: random readiness, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid) rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_req(logic kind, logic [31:0] seed);
    req_t r;
    r.kind = kind;
    r.seed = seed;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_values.size() > 0)
      @(posedge clk);
    // A trailing seed transaction may still be running its warm-up.
    repeat (80) @(posedge clk);
  endtask

  task automatic write_algorithm(logic [2:0] code);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_ALGORITHM;
    pwdata <= {29'd0, code};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    alg_sel = code;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    logic [2:0] code;
    alg_sel = sprng_pkg::ALG_SPLITMIX;
    for (int i = 0; i < 4; i++) st[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: next on the reset state, extreme seeds, every algorithm code.
    queue_req(REQ_NEXT, 32'd0);
    queue_req(REQ_NEXT, 32'hFFFFFFFF);
    drain();
    for (int a = 0; a < 8; a++) begin
      write_algorithm(a[2:0]);
      queue_req(REQ_SEED, (a % 2) ? 32'hFFFFFFFF : 32'd0);
      queue_req(REQ_NEXT, 32'h0);
      queue_req(REQ_NEXT, 32'h5A5A5A5A);
      drain();
    end

    // Long receiver hold-off while the sender keeps offering next requests.
    write_algorithm(sprng_pkg::ALG_XOSHIRO);
    queue_req(REQ_SEED, 32'h12345678);
    for (int i = 0; i < 20; i++) queue_req(REQ_NEXT, $urandom);
    hold_off = 200;
    drain();

    // Random phases: reseed occasionally, switch algorithm between phases.
    for (int ph = 0; ph < 24; ph++) begin
      code = (ph < 20) ? 3'(ph % 5) : 3'($urandom_range(0, 7));
      write_algorithm(code);
      for (int i = 0; i < 75; i++) begin
        if ($urandom_range(0, 15) == 0) queue_req(REQ_SEED, $urandom);
        else queue_req(REQ_NEXT, $urandom);
      end
      drain();
    end
    write_algorithm(sprng_pkg::ALG_SPLITMIX);

    $display("Checked %0d values over %0d seed transactions, all algorithm codes.",
             values_seen, seeds_sent);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
